[design/cartridge_bank_mapper_with_irq_top_defines.svh]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_top_defines.svh
// Assertion macros used by the result buffer (cbm_skid); empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam int CHR_BANK_SLOTS = 8;
    localparam int CHR_IDX_W      = $clog2(CHR_BANK_SLOTS);

    typedef enum logic [1:0] {
        OP_REG_WRITE = 2'd0,
        OP_IRQ_TICK  = 2'd1,
        OP_XLAT_CPU  = 2'd2,
        OP_XLAT_PPU  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] address;
        logic [7:0]  data;
        logic        rendering;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] bank;
        logic       irq_line;
        logic       mirror_horizontal;
    } t_out_beat;

    // write decode
    localparam logic [15:0] DEC_MASK      = 16'hF003;
    localparam logic [15:0] REG_PRG_SEL   = 16'h8000;
    localparam logic [15:0] REG_MIRROR    = 16'h9000;
    localparam logic [15:0] REG_MODE      = 16'h9001;
    localparam logic [15:0] REG_PRG_MID   = 16'hA000;
    localparam logic [15:0] REG_IRQ_LO    = 16'hF000;
    localparam logic [15:0] REG_IRQ_ACK_A = 16'hF001;
    localparam logic [15:0] REG_IRQ_HI    = 16'hF002;
    localparam logic [15:0] REG_IRQ_ACK_B = 16'hF003;
    localparam logic [15:0] CHR_REG_FIRST = 16'hB000;
    localparam logic [15:0] CHR_REG_LAST  = 16'hE003;

    localparam logic [CHR_IDX_W-1:0] CHR_IDX_BIAS = CHR_IDX_W'(6);

    localparam logic [15:0] CPU_ROM_BASE    = 16'h8000;
    localparam logic [15:0] PPU_PATTERN_TOP = 16'h2000;

    localparam logic [7:0] PRG_SECOND_LAST = 8'hFE;
    localparam logic [7:0] PRG_LAST        = 8'hFF;
    localparam logic [7:0] PRG_MASK_RESET  = 8'hFF;
    localparam logic [7:0] IRQ_MATCH       = 8'd238;
    localparam logic [7:0] IRQ_RENDER_STEP = 8'd8;

endpackage

`default_nettype wire

[design/cartridge_bank_mapper_with_irq_top.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_top
// Cartridge bank mapper with IRQ counter: register writes, ticks, translates.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one t_in_beat per beat (opcode,
// address, data, rendering). Every accepted beat yields exactly one t_out_beat
// on o_out_valid / i_out_stall: the translated bank (0 for writes and ticks),
// and the IRQ line and mirroring as they stand after the beat.
// Config channel: i_cfg_valid / o_cfg_ready writes the 8-bit PRG bank mask;
// o_cfg_ready is always high. Write it only while the block is idle.
// State update and result are formed in the accept cycle from combinational
// decode against the bank and counter registers, and the result is registered.
// Throughput is one beat per cycle while the output buffer is not full.
// A two-entry output buffer keeps input accepted while one result waits; the
// input stalls only when both entries hold results the receiver has not taken.
// Reset (synchronous, active low) restores the power-on banks (slot 2 at the
// second-to-last bank), clears CHR banks, counter, enable and pending, sets the
// mask to all ones and empties the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_with_irq_top
    import cbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_beat   i_in_beat,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_beat       o_out_beat
);

    logic      accept;
    logic      buf_full;
    t_out_beat result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full;

    cbm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_beat     (i_in_beat),
        .o_result   (result)
    );

    cbm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_beat  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

[design/cbm_core.sv]
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state, write decode, IRQ counter and bank translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_core
    import cbm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic      i_accept,
    input  wire t_in_beat  i_beat,
    output t_out_beat      o_result
);

    logic [7:0] r_prg_mask;
    logic [7:0] r_prg [3];
    logic       r_mode;
    logic [7:0] r_chr [CHR_BANK_SLOTS];
    logic       r_mirror;
    logic       r_irq_en;
    logic [7:0] r_irq_cnt;
    logic       r_irq_pend;

    logic [7:0] n_prg [3];
    logic       n_mode;
    logic [7:0] n_chr [CHR_BANK_SLOTS];
    logic       n_mirror;
    logic       n_irq_en;
    logic [7:0] n_irq_cnt;
    logic       n_irq_pend;

    logic [15:0]          addr;
    logic [7:0]           wdata;
    logic [15:0]          dec;
    logic [CHR_IDX_W-1:0] chr_wr_idx;
    logic [CHR_IDX_W-1:0] chr_rd_idx;
    logic [7:0]           bank;

    assign addr       = i_beat.address;
    assign wdata      = i_beat.data;
    assign dec        = addr & DEC_MASK;
    assign chr_wr_idx = (addr[11 +: CHR_IDX_W] - CHR_IDX_BIAS)
                      | {{(CHR_IDX_W-1){1'b0}}, addr[0]};
    assign chr_rd_idx = addr[10 +: CHR_IDX_W];

    always_comb begin
        n_prg      = r_prg;
        n_mode     = r_mode;
        n_chr      = r_chr;
        n_mirror   = r_mirror;
        n_irq_en   = r_irq_en;
        n_irq_cnt  = r_irq_cnt;
        n_irq_pend = r_irq_pend;
        bank       = 8'd0;
        unique case (i_beat.opcode)
            OP_REG_WRITE: begin
                if (addr >= CHR_REG_FIRST && addr <= CHR_REG_LAST) begin
                    if (addr[1]) begin
                        n_chr[chr_wr_idx] = {wdata[3:0], r_chr[chr_wr_idx][3:0]};
                    end else begin
                        n_chr[chr_wr_idx] = {r_chr[chr_wr_idx][7:4], wdata[3:0]};
                    end
                end else begin
                    unique case (dec)
                        REG_PRG_SEL: begin
                            if (r_mode) begin
                                n_prg[0] = PRG_SECOND_LAST;
                                n_prg[2] = wdata;
                            end else begin
                                n_prg[0] = wdata;
                                n_prg[2] = PRG_SECOND_LAST;
                            end
                        end
                        REG_MODE: begin
                            n_mode = wdata[1];
                            if (wdata[1]) begin
                                n_prg[0] = PRG_SECOND_LAST;
                                n_prg[2] = r_prg[0];
                            end else begin
                                n_prg[2] = PRG_SECOND_LAST;
                            end
                        end
                        REG_MIRROR:  n_mirror = wdata[0];
                        REG_PRG_MID: n_prg[1] = wdata;
                        REG_IRQ_LO:  n_irq_cnt = {r_irq_cnt[7:4], wdata[3:0]};
                        REG_IRQ_HI:  n_irq_cnt = {wdata[3:0], r_irq_cnt[3:0]};
                        REG_IRQ_ACK_A, REG_IRQ_ACK_B: begin
                            n_irq_en   = wdata[1];
                            n_irq_pend = 1'b0;
                            if (i_beat.rendering) begin
                                n_irq_cnt = r_irq_cnt - IRQ_RENDER_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_IRQ_TICK: begin
                if (r_irq_en) begin
                    n_irq_cnt = r_irq_cnt + 8'd1;
                    if (n_irq_cnt == IRQ_MATCH) begin
                        n_irq_pend = 1'b1;
                    end
                end
            end
            OP_XLAT_CPU: begin
                if (addr >= CPU_ROM_BASE) begin
                    unique case (addr[14:13])
                        2'd0:    bank = r_prg[0] & r_prg_mask;
                        2'd1:    bank = r_prg[1] & r_prg_mask;
                        2'd2:    bank = r_prg[2] & r_prg_mask;
                        default: bank = PRG_LAST & r_prg_mask;
                    endcase
                end
            end
            OP_XLAT_PPU: begin
                if (addr < PPU_PATTERN_TOP) begin
                    bank = r_chr[chr_rd_idx];
                end
            end
            default: ;
        endcase
    end

    assign o_result.bank              = bank;
    assign o_result.irq_line          = n_irq_pend;
    assign o_result.mirror_horizontal = n_mirror;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= PRG_MASK_RESET;
            r_prg[0]   <= 8'd0;
            r_prg[1]   <= 8'd0;
            r_prg[2]   <= PRG_SECOND_LAST;
            r_mode     <= 1'b0;
            for (int i = 0; i < CHR_BANK_SLOTS; i++) begin
                r_chr[i] <= 8'd0;
            end
            r_mirror   <= 1'b0;
            r_irq_en   <= 1'b0;
            r_irq_cnt  <= 8'd0;
            r_irq_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prg_mask <= i_cfg_data;
            end
            if (i_accept) begin
                r_prg      <= n_prg;
                r_mode     <= n_mode;
                r_chr      <= n_chr;
                r_mirror   <= n_mirror;
                r_irq_en   <= n_irq_en;
                r_irq_cnt  <= n_irq_cnt;
                r_irq_pend <= n_irq_pend;
            end
        end
    end

endmodule

`default_nettype wire

[design/cbm_skid.sv]
// ----------------------------------------------------------------------------
// cbm_skid
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cartridge_bank_mapper_with_irq_top_defines.svh"

module cbm_skid
    import cbm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_beat i_beat,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_beat      o_beat
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_beat r_main;
    t_out_beat r_skid;
    logic      pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_beat  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (pop && r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (pop) begin
                r_main_valid <= i_push;
            end else if (i_push && r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else if (i_push) begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push && (pop || !r_main_valid)) begin
            r_main <= i_beat;
        end else if (i_push) begin
            r_skid <= i_beat;
        end
    end

    `CBM_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid, "skid beat without main beat")
    `CBM_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, pop && r_skid_valid, r_main_valid && !r_skid_valid, "skid beat lost on drain")
    `CBM_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, i_push && r_main_valid && !pop, r_skid_valid, "beat dropped under stall")
    `CBM_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, r_skid_valid, !i_push, "push into full buffer")

endmodule

`default_nettype wire
